// File: src/fspc_pkg.sv
// Shared types and constants of the feathered seam pixel compositor.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fspc_pkg;

   localparam int COORD_W    = 12;
   localparam int CHAN_W     = 8;
   localparam int EXTENT_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_VERTICAL = 3'd0,
      CSR_SWAP_SIDES    = 3'd1,
      CSR_FILTER_MODE   = 3'd2,
      CSR_SEAM_EDGE     = 3'd3,
      CSR_REF_ROWS      = 3'd4,
      CSR_REF_COLS      = 3'd5,
      CSR_FRAME_COLS    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CHAN_W-1:0]  ref_blue;
      logic [CHAN_W-1:0]  ref_green;
      logic [CHAN_W-1:0]  ref_red;
      logic [CHAN_W-1:0]  new_blue;
      logic [CHAN_W-1:0]  new_green;
      logic [CHAN_W-1:0]  new_red;
      logic               ref_nonzero;
      logic               new_nonzero;
   } fspc_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic              pixel_written;
   } fspc_rsp_type;

endpackage

`default_nettype wire

// File: src/fspc_recip_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp reciprocal.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module fspc_recip_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: src/feathered_seam_pixel_compositor_top.sv
// Top level of the feathered seam pixel compositor: sequencer, shared multiplier, CSRs.
// Depends on fspc_pkg and fspc_recip_div.
//
//   port group | direction | handshake         | payload
//   req_       | in        | req_valid / stall | fspc_req_type
//   rsp_       | out       | rsp_valid / stall | fspc_rsp_type
//   csr_       | in        | csr_wr_en         | csr_index, csr_data
//
// One item at a time; a blended pixel takes one multiply for the weight and six
// for the channel products, all on one multiplier. The first blended pixel after
// reset or a CSR write adds the reciprocal division, one quotient bit per cycle,
// unless it lies on the seam edge. Reset is synchronous. A result held by rsp_stall
// admits one more item; its result waits, req_stall high, until the held one is sent.
`timescale 1ns / 1ps
`default_nettype none

module feathered_seam_pixel_compositor_top #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire fspc_pkg::fspc_req_type               req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output fspc_pkg::fspc_rsp_type                    rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [fspc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fspc_pkg::CSR_DATA_W-1:0]      csr_data
);

   import fspc_pkg::*;

   localparam int W      = WEIGHT_FRAC_BITS;
   localparam int WT_W   = W + 1;
   localparam int NUM_W  = ((WT_W > COORD_W) ? WT_W : COORD_W) + 1;
   localparam int MUL_AW = (COORD_W > CHAN_W) ? COORD_W : CHAN_W;
   localparam int PROD_W = MUL_AW + WT_W;

   localparam logic [WT_W-1:0]   WONE = {1'b1, {W{1'b0}}};
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (W - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_WEIGHT = 5'b01000,
      ST_MIX    = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      SEL_NONE  = 2'd0,
      SEL_REF   = 2'd1,
      SEL_NEW   = 2'd2,
      SEL_BLEND = 2'd3
   } sel_type;

   localparam logic [2:0] MIX_LAST = 3'd5;

   state_type state_ff, state_in;
   logic      done_ff, done_in;
   fspc_req_type item_ff, item_in;

   logic                axis_ff, axis_in;
   logic                swap_ff, swap_in;
   logic                filter_ff, filter_in;
   logic [COORD_W-1:0]  edge_pos_ff, edge_pos_in;
   logic [EXTENT_W-1:0] ref_rows_ff, ref_rows_in;
   logic [EXTENT_W-1:0] ref_cols_ff, ref_cols_in;
   logic [EXTENT_W-1:0] frame_cols_ff, frame_cols_in;

   logic               latched_ff, latched_in;
   logic [COORD_W-1:0] pos_ff, pos_in;
   logic [WT_W-1:0]    recip_ff, recip_in;
   logic [WT_W-1:0]    t_ff, t_in;
   logic [2:0]         step_ff, step_in;
   logic [CHAN_W-1:0]  rnd_ff, rnd_in;
   logic [CHAN_W-1:0]  ch_ff [3];
   logic [CHAN_W-1:0]  ch_in [3];
   logic               written_ff, written_in;

   logic         rsp_valid_ff, rsp_valid_in;
   fspc_rsp_type rsp_data_ff, rsp_data_in;

   logic               inb, refm, skip, overlap, ref_fav;
   sel_type            sel;
   logic [COORD_W-1:0] coord, seam_dist, dpos;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_numer, div_quo;
   logic [CHAN_W-1:0]  rp [3];
   logic [CHAN_W-1:0]  np [3];
   logic [CHAN_W-1:0]  fav, oth;
   logic [MUL_AW-1:0]  mul_a;
   logic [WT_W-1:0]    mul_b;
   logic [PROD_W-1:0]  prod, prod_rnd;
   logic [CHAN_W-1:0]  rnd_now;
   logic [CHAN_W:0]    sum;
   logic               out_free;

   assign rp[0] = item_ff.ref_blue;
   assign rp[1] = item_ff.ref_green;
   assign rp[2] = item_ff.ref_red;
   assign np[0] = item_ff.new_blue;
   assign np[1] = item_ff.new_green;
   assign np[2] = item_ff.new_red;

   always_comb begin
      inb  = ({1'b0, item_ff.row} < ref_rows_ff) && ({1'b0, item_ff.col} < ref_cols_ff);
      refm = inb && item_ff.ref_nonzero;
      skip = (item_ff.row == '0) || (item_ff.col == '0);
      if (axis_ff) begin
         if (({1'b0, item_ff.col} + 1'b1) >= frame_cols_ff) skip = 1'b1;
      end else begin
         if ({1'b0, item_ff.col} >= frame_cols_ff) skip = 1'b1;
      end
      overlap = refm && item_ff.new_nonzero;
      sel = SEL_NONE;
      if (!skip) begin
         if (filter_ff) begin
            if (overlap) sel = SEL_BLEND;
            else if (refm) sel = SEL_REF;
            else if (!axis_ff || item_ff.new_nonzero) sel = SEL_NEW;
         end else begin
            if (axis_ff) sel = inb ? SEL_REF : SEL_NEW;
            else if (refm) sel = SEL_REF;
            else if (item_ff.new_nonzero) sel = SEL_NEW;
         end
      end
      coord     = axis_ff ? item_ff.row : item_ff.col;
      seam_dist = (edge_pos_ff > coord) ? edge_pos_ff - coord : coord - edge_pos_ff;
      dpos      = (coord > pos_ff) ? coord - pos_ff : pos_ff - coord;
      div_numer = NUM_W'(WONE) + NUM_W'(seam_dist >> 1);
      ref_fav   = swap_ff ^ axis_ff;
   end

   always_comb begin
      unique case (step_ff[2:1])
         2'd0:    begin fav = ref_fav ? rp[0] : np[0]; oth = ref_fav ? np[0] : rp[0]; end
         2'd1:    begin fav = ref_fav ? rp[1] : np[1]; oth = ref_fav ? np[1] : rp[1]; end
         default: begin fav = ref_fav ? rp[2] : np[2]; oth = ref_fav ? np[2] : rp[2]; end
      endcase
      if (state_ff == ST_WEIGHT) begin
         mul_a = MUL_AW'(dpos);
         mul_b = recip_ff;
      end else begin
         mul_a = MUL_AW'(step_ff[0] ? oth : fav);
         mul_b = step_ff[0] ? WONE - t_ff : t_ff;
      end
      prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_rnd = prod + HALF;
      rnd_now  = prod_rnd[W +: CHAN_W];
      sum      = {1'b0, rnd_ff} + {1'b0, rnd_now};
   end

   fspc_recip_div #(
      .NUM_W (NUM_W),
      .DEN_W (COORD_W)
   ) u_recip_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (seam_dist),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || done_ff;

   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      item_in       = item_ff;
      axis_in       = axis_ff;
      swap_in       = swap_ff;
      filter_in     = filter_ff;
      edge_pos_in   = edge_pos_ff;
      ref_rows_in   = ref_rows_ff;
      ref_cols_in   = ref_cols_ff;
      frame_cols_in = frame_cols_ff;
      latched_in    = latched_ff;
      pos_in        = pos_ff;
      recip_in      = recip_ff;
      t_in          = t_ff;
      step_in       = step_ff;
      rnd_in        = rnd_ff;
      ch_in         = ch_ff;
      written_in    = written_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (done_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_blue: ch_ff[0], out_green: ch_ff[1],
                                   out_red: ch_ff[2], pixel_written: written_ff};
                  done_in      = 1'b0;
               end
            end else if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            written_in = (sel != SEL_NONE);
            for (int k = 0; k < 3; k++) begin
               unique case (sel)
                  SEL_REF: ch_in[k] = rp[k];
                  SEL_NEW: ch_in[k] = np[k];
                  default: ch_in[k] = '0;
               endcase
            end
            if (sel == SEL_BLEND) begin
               if (latched_ff) begin
                  state_in = ST_WEIGHT;
               end else if (seam_dist == '0) begin
                  recip_in   = '0;
                  pos_in     = coord;
                  latched_in = 1'b1;
                  state_in   = ST_WEIGHT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               recip_in   = (div_quo == '0) ? WT_W'(1) : div_quo[WT_W-1:0];
               pos_in     = coord;
               latched_in = 1'b1;
               state_in   = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (recip_ff == '0 || prod > PROD_W'(WONE)) t_in = WONE;
            else t_in = prod[WT_W-1:0];
            step_in  = '0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (!step_ff[0]) begin
               rnd_in = rnd_now;
            end else begin
               unique case (step_ff[2:1])
                  2'd0:    ch_in[0] = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
                  2'd1:    ch_in[1] = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
                  default: ch_in[2] = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
               endcase
            end
            step_in = step_ff + 1'b1;
            if (step_ff == MIX_LAST) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AXIS_VERTICAL: begin axis_in = csr_data[0];                 latched_in = 1'b0; end
            CSR_SWAP_SIDES:    begin swap_in = csr_data[0];                 latched_in = 1'b0; end
            CSR_FILTER_MODE:   begin filter_in = csr_data[0];               latched_in = 1'b0; end
            CSR_SEAM_EDGE:     begin edge_pos_in = csr_data[COORD_W-1:0];   latched_in = 1'b0; end
            CSR_REF_ROWS:      begin ref_rows_in = csr_data[EXTENT_W-1:0];  latched_in = 1'b0; end
            CSR_REF_COLS:      begin ref_cols_in = csr_data[EXTENT_W-1:0];  latched_in = 1'b0; end
            CSR_FRAME_COLS:    begin frame_cols_in = csr_data[EXTENT_W-1:0]; latched_in = 1'b0; end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= 1'b0;
         swap_ff       <= 1'b0;
         filter_ff     <= 1'b1;
         edge_pos_ff   <= '0;
         ref_rows_ff   <= '0;
         ref_cols_ff   <= '0;
         frame_cols_ff <= '0;
         latched_ff    <= 1'b0;
         pos_ff        <= '0;
         recip_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         axis_ff       <= axis_in;
         swap_ff       <= swap_in;
         filter_ff     <= filter_in;
         edge_pos_ff   <= edge_pos_in;
         ref_rows_ff   <= ref_rows_in;
         ref_cols_ff   <= ref_cols_in;
         frame_cols_ff <= frame_cols_in;
         latched_ff    <= latched_in;
         pos_ff        <= pos_in;
         recip_ff      <= recip_in;
      end
      item_ff     <= item_in;
      t_ff        <= t_in;
      step_ff     <= step_in;
      rnd_ff      <= rnd_in;
      ch_ff       <= ch_in;
      written_ff  <= written_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
